// ----- rtl/hmac_pkg.sv -----
// Shared types, constants and functions of the HMAC-SHA256 engine.
package hmac_pkg;

  localparam int unsigned MaxMessageBytes = 4096;
  localparam int unsigned LenW = 13;
  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        drop;
    logic        start;
  } hmac_cmd_t;

  typedef enum logic [3:0] {
    StIdle, StLoad, StIpad, StByte, StRound, StAdd, StPad, StOpad,
    StOuter, StDone
  } hmac_state_e;

  typedef enum logic [1:0] {
    BlkIpad, BlkMsg, BlkOpad, BlkOuter
  } hmac_blk_e;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/hmac_front.sv -----
// Front end: accepts message requests, tracks length and overflow.
module hmac_front import hmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] msg_data_i,
  input  logic [3:0]  msg_bytes_i,
  input  logic        msg_last_i,
  output logic        cmd_valid_o,
  output hmac_cmd_t   cmd_o,
  input  logic        cmd_pop_i
);

  localparam int unsigned Depth = 2;

  hmac_cmd_t   fifo_q [Depth];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic [LenW-1:0] len_q;
  logic        exc_q, started_q;
  logic [3:0]  nb;
  logic [LenW:0] sum;
  logic        drop, acc;
  hmac_cmd_t   cmd;

  assign full = (cnt_q == 2'(Depth));
  assign acc = push && !full;
  assign nb = (msg_bytes_i > 4'd8) ? 4'd8 : msg_bytes_i;
  assign sum = {1'b0, len_q} + (LenW+1)'(nb);
  assign drop = exc_q || (sum > (LenW+1)'(MaxMessageBytes));

  always_comb begin
    cmd = '0;
    cmd.data = msg_data_i;
    cmd.nbytes = drop ? 4'd0 : nb;
    cmd.last = msg_last_i;
    cmd.drop = drop;
    cmd.start = !started_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q <= '0;
      len_q <= '0;
      exc_q <= 1'b0;
      started_q <= 1'b0;
    end else begin
      if (acc) begin
        wptr_q <= ~wptr_q;
        if (msg_last_i) begin
          len_q <= '0;
          exc_q <= 1'b0;
          started_q <= 1'b0;
        end else begin
          started_q <= 1'b1;
          exc_q <= drop;
          if (!drop) len_q <= sum[LenW-1:0];
        end
      end
      if (cmd_pop_i && cnt_q != 2'd0) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(cmd_pop_i && cnt_q != 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) fifo_q[wptr_q] <= cmd;
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rptr_q];

endmodule

// ----- rtl/hmac_back.sv -----
// Back end: SHA-256 round engine with block assembly and HMAC sequencing.
module hmac_back import hmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] key_i [4],
  input  logic        cmd_valid_i,
  input  hmac_cmd_t   cmd_i,
  output logic        cmd_pop_o,
  output logic        res_valid_o,
  output logic [255:0] res_digest_o,
  output logic        res_ok_o,
  input  logic        res_pop_i
);

  hmac_state_e state_q, state_d;
  hmac_blk_e   blk_q, blk_d;
  hmac_cmd_t   cmd_q;
  logic [31:0] h_q [8];
  logic [31:0] inner_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] buf_q [16];
  logic [5:0]  pos_q;
  logic [LenW-1:0] len_q;
  logic [5:0]  rnd_q;
  logic [3:0]  bi_q;
  logic        padtwo_q;
  logic        fin_q;
  logic        res_valid_q;
  logic [255:0] res_q;
  logic        ok_q;

  logic [7:0]  cur_byte;
  logic [7:0]  blk_byte [64];
  logic [7:0]  pad_byte [64];
  logic [63:0] len_bits;
  logic [31:0] wt, t1, t2, s0, s1, x2, x15;
  logic [7:0]  pad;

  // byte j of the block that the current pass hashes
  always_comb begin
    pad = (blk_q == BlkOpad) ? OpadByte : IpadByte;
    for (int j = 0; j < 64; j++) begin
      case (blk_q)
        BlkIpad, BlkOpad: begin
          if (j < 32) blk_byte[j] = key_i[j/8][63-8*(j%8) -: 8] ^ pad;
          else blk_byte[j] = pad;
        end
        BlkMsg: blk_byte[j] = buf_q[j/4][31-8*(j%4) -: 8];
        BlkOuter: begin
          if (j < 32) blk_byte[j] = inner_q[j/4][31-8*(j%4) -: 8];
          else if (j == 32) blk_byte[j] = 8'h80;
          else if (j == 62) blk_byte[j] = 8'h03;
          else blk_byte[j] = 8'h00;
        end
        default: blk_byte[j] = 8'h00;
      endcase
    end
  end

  // padded block: 0x80 after the message, zeros, and the bit length (key block included)
  always_comb begin
    len_bits = ({51'd0, len_q} + 64'd64) << 3;
    for (int j = 0; j < 64; j++) begin
      if (padtwo_q || j > pos_q) pad_byte[j] = 8'h00;
      else if (j == pos_q) pad_byte[j] = 8'h80;
      else pad_byte[j] = buf_q[j/4][31-8*(j%4) -: 8];
      if (j >= 56 && (padtwo_q || pos_q < 6'd56)) pad_byte[j] = len_bits[8*(63-j) +: 8];
    end
  end

  always_comb begin
    x2 = w_q[4'(rnd_q - 6'd2)];
    x15 = w_q[4'(rnd_q - 6'd15)];
    s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    if (rnd_q < 6'd16) begin
      wt = {blk_byte[{rnd_q[3:0], 2'd0}], blk_byte[{rnd_q[3:0], 2'd1}],
            blk_byte[{rnd_q[3:0], 2'd2}], blk_byte[{rnd_q[3:0], 2'd3}]};
    end else begin
      wt = w_q[rnd_q[3:0]] + s1 + w_q[4'(rnd_q - 6'd7)] + s0;
    end
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + wt;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    cur_byte = cmd_q.data[63 - 8*bi_q[2:0] -: 8];
  end

  always_comb begin
    state_d = state_q;
    blk_d = blk_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i && !res_valid_q) begin
          cmd_pop_o = 1'b1;
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (cmd_q.start) begin
          state_d = StRound;
          blk_d = BlkIpad;
        end else state_d = StByte;
      end
      StByte: begin
        if (bi_q >= cmd_q.nbytes) begin
          if (!cmd_q.last) state_d = StIdle;
          else if (cmd_q.drop) state_d = StDone;
          else state_d = StPad;
        end else if (pos_q == 6'd63) begin
          state_d = StRound;
          blk_d = BlkMsg;
        end
      end
      StRound: begin
        if (rnd_q == 6'd63) state_d = StAdd;
      end
      StAdd: begin
        case (blk_q)
          BlkIpad: state_d = StByte;
          BlkMsg: begin
            if (fin_q) state_d = StOpad;
            else if (padtwo_q) state_d = StPad;
            else state_d = StByte;
          end
          BlkOpad: begin
            state_d = StRound;
            blk_d = BlkOuter;
          end
          BlkOuter: state_d = StDone;
          default: state_d = StIdle;
        endcase
      end
      StPad: begin
        state_d = StRound;
        blk_d = BlkMsg;
      end
      StOpad: begin
        state_d = StRound;
        blk_d = BlkOpad;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      blk_q <= BlkIpad;
      res_valid_q <= 1'b0;
      rnd_q <= '0;
      bi_q <= '0;
      pos_q <= '0;
      len_q <= '0;
      padtwo_q <= 1'b0;
      fin_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      blk_q <= blk_d;
      if (res_pop_i && res_valid_q) res_valid_q <= 1'b0;
      case (state_q)
        StLoad: begin
          bi_q <= '0;
          if (cmd_q.start) begin
            for (int i = 0; i < 8; i++) begin
              h_q[i] <= InitHash[i];
              v_q[i] <= InitHash[i];
            end
            rnd_q <= '0;
            pos_q <= '0;
            len_q <= '0;
            padtwo_q <= 1'b0;
            fin_q <= 1'b0;
          end
        end
        StByte: begin
          if (bi_q < cmd_q.nbytes) begin
            buf_q[pos_q[5:2]][31 - 8*pos_q[1:0] -: 8] <= cur_byte;
            pos_q <= pos_q + 6'd1;
            len_q <= len_q + 1'b1;
            bi_q <= bi_q + 4'd1;
            if (pos_q == 6'd63) begin
              rnd_q <= '0;
              for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            end
          end
        end
        StRound: begin
          w_q[rnd_q[3:0]] <= wt;
          for (int i = 0; i < 8; i++) begin
            if (i == 0) v_q[0] <= t1 + t2;
            else if (i == 4) v_q[4] <= v_q[3] + t1;
            else v_q[i] <= v_q[i-1];
          end
          rnd_q <= rnd_q + 6'd1;
        end
        StAdd: begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) begin
            if (blk_q == BlkOpad) begin
              h_q[i] <= InitHash[i] + v_q[i];
              v_q[i] <= InitHash[i] + v_q[i];
            end else h_q[i] <= h_q[i] + v_q[i];
          end
          if (blk_q == BlkMsg && fin_q) begin
            for (int i = 0; i < 8; i++) inner_q[i] <= h_q[i] + v_q[i];
            for (int i = 0; i < 8; i++) v_q[i] <= InitHash[i];
            fin_q <= 1'b0;
          end
          if (blk_q == BlkOuter) begin
            for (int i = 0; i < 8; i++) res_q[255-32*i -: 32] <= h_q[i] + v_q[i];
          end
        end
        StPad: begin
          // append 0x80, zeros, and the bit length (key block included)
          for (int k = 0; k < 16; k++) begin
            buf_q[k] <= {pad_byte[4*k], pad_byte[4*k+1], pad_byte[4*k+2], pad_byte[4*k+3]};
          end
          if (!padtwo_q && pos_q > 6'd55) padtwo_q <= 1'b1;
          else begin
            padtwo_q <= 1'b0;
            fin_q <= 1'b1;
          end
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          rnd_q <= '0;
        end
        StOpad: rnd_q <= '0;
        StDone: begin
          res_valid_q <= 1'b1;
          ok_q <= !cmd_q.drop;
          if (cmd_q.drop) res_q <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
  end

  assign res_valid_o = res_valid_q;
  assign res_digest_o = res_q;
  assign res_ok_o = ok_q;

endmodule

// ----- rtl/hmac_sha256_engine.sv -----
// Top level of the HMAC-SHA256 engine: key registers, front end, back end.
//  channel | handshake     | payload
//  input   | push / full   | msg_data_i, msg_bytes_i, msg_last_i
//  result  | pop / empty   | digest_word_0..3_o, mac_ok_o
//  config  | cfg_we_i      | cfg_idx_i, cfg_wdata_i
// An item is loaded and its bytes go into the block buffer one at a time; each filled
// 64-byte block runs through the single-round SHA-256 core, as does the inner pad block
// on the first item. The last item adds one or two padding blocks, the outer pad block
// and the outer block, then posts the result; a dropped message skips to the result.
// Reset clears the control state and the key registers.
// A two-entry request queue lets input run ahead of the round core; the core
// holds when a result waits unpopped.
module hmac_sha256_engine import hmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] msg_data_i,
  input  logic [3:0]  msg_bytes_i,
  input  logic        msg_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_word_0_o,
  output logic [63:0] digest_word_1_o,
  output logic [63:0] digest_word_2_o,
  output logic [63:0] digest_word_3_o,
  output logic        mac_ok_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0] key_q [4];
  logic        cmd_valid, cmd_pop, res_valid, res_ok;
  hmac_cmd_t   cmd;
  logic [255:0] res_digest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  hmac_front u_front (
    .clk_i, .rst_ni, .push, .full, .msg_data_i, .msg_bytes_i, .msg_last_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  hmac_back u_back (
    .clk_i, .rst_ni, .key_i(key_q), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_pop_o(cmd_pop), .res_valid_o(res_valid), .res_digest_o(res_digest),
    .res_ok_o(res_ok), .res_pop_i(pop)
  );

  assign empty = !res_valid;
  assign digest_word_0_o = res_digest[255:192];
  assign digest_word_1_o = res_digest[191:128];
  assign digest_word_2_o = res_digest[127:64];
  assign digest_word_3_o = res_digest[63:0];
  assign mac_ok_o = res_ok;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !mac_ok_o) |-> (digest_word_0_o == 64'd0 && digest_word_3_o == 64'd0))
    else $error("error result carries a nonzero digest");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(digest_word_0_o)))
    else $error("waiting result changed");
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back end took a request from an empty queue");

endmodule

// ----- bench/tb_hmac_sha256_engine.sv -----
// Self-checking testbench for the HMAC-SHA256 engine: streamed messages, checked MACs.
`timescale 1ns / 100ps

module tb_hmac_sha256_engine;
  import hmac_pkg::*;

  localparam logic [1:0] KeyWord0 = 2'd0;
  localparam logic [1:0] KeyWord1 = 2'd1;
  localparam logic [1:0] KeyWord2 = 2'd2;
  localparam logic [1:0] KeyWord3 = 2'd3;
  localparam int unsigned SettleCycles = 400;
  localparam int unsigned StallLimit = 20000;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } msg_item_t;

  typedef struct {
    logic [255:0] mac;
    logic         ok;
  } mac_result_t;

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  logic [63:0] msg_data_i;
  logic [3:0]  msg_bytes_i;
  logic        msg_last_i;
  logic [63:0] digest_word_0_o, digest_word_1_o, digest_word_2_o, digest_word_3_o;
  logic        mac_ok_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  hmac_sha256_engine uut (.*);

  msg_item_t   msg_pending[$];
  mac_result_t mac_expected[$];
  int unsigned errors, items_in, macs_out, key_settings;

  // predictor state
  logic [63:0]  key_q [4];
  logic [255:0] chain_h;
  logic [511:0] msg_block;
  int unsigned  msg_len;
  logic         too_long, in_msg;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(input logic [255:0] h, input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) w[t] = blk[511 - 32 * t -: 32];
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, hh} = h;
    for (int t = 0; t < 64; t++) begin
      t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + RoundK[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {h[255:224] + a, h[223:192] + b, h[191:160] + c, h[159:128] + d,
            h[127:96] + e, h[95:64] + f, h[63:32] + g, h[31:0] + hh};
  endfunction

  function automatic logic [255:0] pad_block_hash(input logic [7:0] pad);
    logic [255:0] iv;
    for (int i = 0; i < 8; i++) iv[255 - 32 * i -: 32] = InitHash[i];
    return sha_compress(iv, {key_q[0], key_q[1], key_q[2], key_q[3], 256'd0} ^ {64{pad}});
  endfunction

  // Absorb one accepted request; a last request queues the expected MAC.
  task automatic hmac_absorb(input msg_item_t it);
    int unsigned  nb, pos;
    logic [255:0] outer;
    mac_result_t  r;
    nb = (it.nbytes > 8) ? 8 : it.nbytes;
    if (!in_msg) begin
      chain_h = pad_block_hash(IpadByte);
      msg_len = 0;
      in_msg = 1'b1;
    end
    if (!too_long) begin
      if (msg_len + nb > MaxMessageBytes) too_long = 1'b1;
      else begin
        for (int i = 0; i < nb; i++) begin
          msg_block[511 - 8 * (msg_len % 64) -: 8] = it.data[63 - 8 * i -: 8];
          msg_len++;
          if (msg_len % 64 == 0) chain_h = sha_compress(chain_h, msg_block);
        end
      end
    end
    if (!it.last) return;
    if (too_long) begin
      r.mac = '0;
      r.ok = 1'b0;
    end else begin
      pos = msg_len % 64;
      msg_block[511 - 8 * pos -: 8] = 8'h80;
      pos++;
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) msg_block[511 - 8 * i -: 8] = 8'h00;
        chain_h = sha_compress(chain_h, msg_block);
        pos = 0;
      end
      for (int i = pos; i < 56; i++) msg_block[511 - 8 * i -: 8] = 8'h00;
      msg_block[63:0] = 64'(msg_len + 64) * 64'd8;
      chain_h = sha_compress(chain_h, msg_block);
      outer = sha_compress(pad_block_hash(OpadByte), {chain_h, 8'h80, 184'd0, 64'd768});
      r.mac = outer;
      r.ok = 1'b1;
    end
    mac_expected.push_back(r);
    chain_h = '0;
    msg_len = 0;
    too_long = 1'b0;
    in_msg = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, macs_out);
    errors++;
  endtask

  // Driver: bursts of random length, random gaps between them.
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      msg_data_i <= '0;
      msg_bytes_i <= '0;
      msg_last_i <= 1'b0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        hmac_absorb(msg_pending.pop_front());
        items_in++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (msg_pending.size() > 0) begin
          push <= 1'b1;
          msg_data_i <= msg_pending[0].data;
          msg_bytes_i <= msg_pending[0].nbytes;
          msg_last_i <= msg_pending[0].last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pop with a changing stall rate, compare against the oldest MAC.
  int unsigned pop_pct, stall_tick;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_pct = 100;
      stall_tick = 0;
    end else begin
      if (pop && !empty) begin
        if (mac_expected.size() == 0) begin
          $display("MISMATCH: result with no message pending");
          errors++;
        end else begin
          mac_result_t want;
          want = mac_expected.pop_front();
          if (digest_word_0_o !== want.mac[255:192])
            note_mismatch("digest_word_0", digest_word_0_o, want.mac[255:192]);
          if (digest_word_1_o !== want.mac[191:128])
            note_mismatch("digest_word_1", digest_word_1_o, want.mac[191:128]);
          if (digest_word_2_o !== want.mac[127:64])
            note_mismatch("digest_word_2", digest_word_2_o, want.mac[127:64]);
          if (digest_word_3_o !== want.mac[63:0])
            note_mismatch("digest_word_3", digest_word_3_o, want.mac[63:0]);
          if (mac_ok_o !== want.ok) note_mismatch("mac_ok", 64'(mac_ok_o), 64'(want.ok));
        end
        macs_out++;
      end
      stall_tick++;
      if (stall_tick % 300 == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 100;
          1: pop_pct = 60;
          default: pop_pct = 10;
        endcase
      end
      pop <= ($urandom_range(0, 99) < pop_pct);
    end
  end

  // Watchdog on cycles with no request moving either way.
  int unsigned idle_cycles;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("Timeout: no handshake for %0d cycles", StallLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (msg_pending.size() > 0 || push || mac_expected.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_keys(input logic [63:0] k0, k1, k2, k3);
    logic [63:0] vals [4];
    logic [1:0]  idxs [4];
    vals = '{k0, k1, k2, k3};
    idxs = '{KeyWord0, KeyWord1, KeyWord2, KeyWord3};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idxs[i];
      cfg_wdata_i <= vals[i];
      key_q[idxs[i]] = vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_settings++;
  endtask

  task automatic queue_item(input logic [63:0] d, input logic [3:0] nb, input logic last);
    msg_item_t it;
    it.data = d;
    it.nbytes = nb;
    it.last = last;
    msg_pending.push_back(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_directed();
    queue_item(rand64(), 4'd0, 1'b1);                   // empty message
    queue_item(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
    queue_item(rand64(), 4'd15, 1'b1);                  // oversized byte count
    queue_item(rand64(), 4'd3, 1'b1);                   // ignored tail bytes
    for (int i = 0; i < 7; i++) queue_item(rand64(), 4'd8, i == 6);  // 56 bytes: extra block
    for (int i = 0; i < 7; i++) queue_item(rand64(), i == 6 ? 4'd7 : 4'd8, i == 6);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = KeyWord0;
    cfg_wdata_i = '0;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    chain_h = '0;
    msg_block = '0;
    msg_len = 0;
    too_long = 1'b0;
    in_msg = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    key_settings = 1;

    // reset key, then all-ones key
    queue_directed();
    wait_drained();
    write_keys('1, '1, '1, '1);
    queue_directed();
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) write_keys('0, '0, '0, '0);
      else write_keys(rand64(), rand64(), rand64(), rand64());
      for (int n = 0; n < 10; ) begin
        int unsigned len;
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++)
          queue_item(rand64(), 4'($urandom_range(0, 15)), i == len - 1);
        n += len;
      end
      wait_drained();
    end

    // exactly the maximum, then one byte over; later requests are discarded
    write_keys(rand64(), 64'h0, rand64(), 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < MaxMessageBytes / 8; i++) queue_item(rand64(), 4'd8, 1'b0);
    queue_item(rand64(), 4'd1, 1'b0);
    queue_item(rand64(), 4'd8, 1'b0);
    queue_item(rand64(), 4'd2, 1'b1);
    queue_item(rand64(), 4'd5, 1'b1);                   // next message is clean again
    wait_drained();

    $display("Ran %0d message requests, %0d MAC results, %0d key settings",
             items_in, macs_out, key_settings);
    $display("Included empty, block-boundary and overlong messages");
    if (errors == 0 && mac_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
